// ----- rtl/jdd_pkg.sv -----
// Package for the joystick dead-man drive control block.
// Holds field widths, mode and event codes and decision thresholds.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jdd_pkg;

  localparam int KIND_W  = 2;
  localparam int NUM_W   = 8;
  localparam int VAL_W   = 16;
  localparam int MODE_W  = 2;
  localparam int CMD_W   = 11;
  localparam int SCALE_W = 10;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_ESTOP = 2'd2
  } mode_t;

  localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd0;
  localparam logic [KIND_W-1:0] KIND_AXIS   = 2'd1;

  localparam logic [NUM_W-1:0] AXIS_TRIGGER   = 8'd2;
  localparam logic [NUM_W-1:0] AXIS_STICK_X   = 8'd3;
  localparam logic [NUM_W-1:0] AXIS_STICK_Y   = 8'd4;
  localparam logic [NUM_W-1:0] BUTTON_RELEASE = 8'd1;

  localparam logic signed [VAL_W-1:0] SWITCH_ON_LEVEL  = 16'sd25000;
  localparam logic signed [VAL_W-1:0] SWITCH_OFF_LEVEL = -16'sd5000;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRAKE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_THROTTLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEER    = 2'd2;

  localparam logic [SCALE_W-1:0] MAX_BRAKE_RST    = 10'd20;
  localparam logic [SCALE_W-1:0] MAX_THROTTLE_RST = 10'd20;
  localparam logic [SCALE_W-1:0] MAX_STEER_RST    = 10'd150;

endpackage

`default_nettype wire

// ----- rtl/jdd_in_if.sv -----
// Gamepad event channel: valid/ready handshake and event payload.
// Depends on jdd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface jdd_in_if import jdd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       event_kind;
  logic [NUM_W-1:0]        control_number;
  logic signed [VAL_W-1:0] event_value;

  modport source (output valid, output event_kind, output control_number,
                  output event_value, input ready);
  modport sink   (input valid, input event_kind, input control_number,
                  input event_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/jdd_out_if.sv -----
// Drive command channel: valid/ready handshake and mode/command payload.
// Depends on jdd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface jdd_out_if import jdd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic signed [CMD_W-1:0] throttle_cmd;
  logic signed [CMD_W-1:0] steer_cmd;

  modport source (output valid, output mode, output throttle_cmd,
                  output steer_cmd, input ready);
  modport sink   (input valid, input mode, input throttle_cmd,
                  input steer_cmd, output ready);
endinterface

`default_nettype wire

// ----- rtl/joystick_deadman_drive_control.sv -----
// Joystick dead-man drive control: mode, throttle and steer from gamepad events.
// Each event is registered in the input stage, then in the state registers that form the result.
// Throughput: one event per cycle unless a held result beat stalls; the stick scale (one
//   16x10 multiply and a shift-add divide by 32767) sits between the input and state registers.
// Reset (rst_n low, synchronous): mode off, commands zero, scales 20/20/150.
// Depends on jdd_pkg, jdd_in_if and jdd_out_if.
`timescale 1ns / 1ps
`default_nettype none

module joystick_deadman_drive_control import jdd_pkg::*; (
  input  wire                  clk,
  input  wire                  rst_n,
  jdd_in_if.sink               in_ch,
  jdd_out_if.source            out_ch,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_idx,
  input  wire [SCALE_W-1:0]    cfg_wdata
);

  localparam int PROD_W = VAL_W + SCALE_W;

  // configuration
  logic [SCALE_W-1:0] max_brake_r, max_throttle_r, max_steer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_brake_r    <= MAX_BRAKE_RST;
      max_throttle_r <= MAX_THROTTLE_RST;
      max_steer_r    <= MAX_STEER_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MAX_BRAKE:    max_brake_r    <= cfg_wdata;
        CFG_MAX_THROTTLE: max_throttle_r <= cfg_wdata;
        CFG_MAX_STEER:    max_steer_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register stage
  logic                    s1_valid_r;
  logic [KIND_W-1:0]       s1_kind_r;
  logic [NUM_W-1:0]        s1_num_r;
  logic signed [VAL_W-1:0] s1_val_r;
  logic                    out_valid_r;
  logic                    s1_adv;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_kind_r <= in_ch.event_kind;
      s1_num_r  <= in_ch.control_number;
      s1_val_r  <= in_ch.event_value;
    end
  end

  // stick scaling: sign-magnitude multiply, then divide by 2^15-1 with
  // q = (p + (p >> 15) + 1) >> 15, exact for p below 2^30 - 1
  logic signed [VAL_W-1:0] neg_val;
  logic signed [VAL_W-1:0] sc_val;
  logic [SCALE_W-1:0]      sc_gain;
  logic                    sc_neg;
  logic [VAL_W-1:0]        sc_mag;
  logic [PROD_W-1:0]       sc_prod;
  logic [PROD_W:0]         sc_sum;
  logic [CMD_W-1:0]        sc_quo;
  logic signed [CMD_W-1:0] sc_res;

  always_comb begin
    neg_val = -s1_val_r;  // wraps at the most negative value
    if (s1_num_r == AXIS_STICK_Y) begin
      sc_val  = neg_val;
      sc_gain = (!neg_val[VAL_W-1] && (neg_val != '0)) ? max_throttle_r : max_brake_r;
    end else begin
      sc_val  = s1_val_r;
      sc_gain = max_steer_r;
    end
    sc_neg  = sc_val[VAL_W-1];
    sc_mag  = sc_neg ? VAL_W'(-sc_val) : VAL_W'(sc_val);
    sc_prod = PROD_W'(sc_mag) * PROD_W'(sc_gain);
    sc_sum  = (PROD_W+1)'(sc_prod) + (PROD_W+1)'(sc_prod >> 15) + (PROD_W+1)'(1);
    sc_quo  = sc_sum[15 +: CMD_W];
    sc_res  = sc_neg ? -$signed(sc_quo) : $signed(sc_quo);
  end

  // mode and command state; the state registers are the result payload
  mode_t                   mode_r, mode_nxt;
  logic signed [CMD_W-1:0] throttle_r, throttle_nxt;
  logic signed [CMD_W-1:0] steer_r, steer_nxt;
  logic                    is_axis, is_trigger;

  always_comb begin
    mode_nxt     = mode_r;
    throttle_nxt = throttle_r;
    steer_nxt    = steer_r;
    is_axis      = (s1_kind_r == KIND_AXIS);
    is_trigger   = is_axis && (s1_num_r == AXIS_TRIGGER);
    unique case (mode_r)
      MODE_ON: begin
        if (is_trigger) begin
          if (s1_val_r < SWITCH_OFF_LEVEL) begin
            mode_nxt     = MODE_ESTOP;
            throttle_nxt = $signed({1'b0, max_brake_r});
            steer_nxt    = '0;
          end
        end else if (is_axis && (s1_num_r == AXIS_STICK_Y)) begin
          throttle_nxt = sc_res;
        end else if (is_axis && (s1_num_r == AXIS_STICK_X)) begin
          steer_nxt = sc_res;
        end
      end
      default: begin
        // stop falls through to the off handling
        if ((mode_r == MODE_ESTOP) && (s1_kind_r == KIND_BUTTON) &&
            (s1_num_r == BUTTON_RELEASE)) begin
          mode_nxt = MODE_OFF;
        end else if (is_trigger && (s1_val_r > SWITCH_ON_LEVEL)) begin
          mode_nxt     = MODE_ON;
          throttle_nxt = '0;
          steer_nxt    = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_OFF;
      throttle_r  <= '0;
      steer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        mode_r     <= mode_nxt;
        throttle_r <= throttle_nxt;
        steer_r    <= steer_nxt;
      end
      // hold the beat until taken, reload when the next event advances
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.mode         = mode_r;
  assign out_ch.throttle_cmd = throttle_r;
  assign out_ch.steer_cmd    = steer_r;

  // checks
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(mode_r) && $stable(throttle_r) && $stable(steer_r))
    else $error("drive state changed without an event advancing");

  a_turn_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ON) && ($past(mode_r) != MODE_ON) |->
      (throttle_r == '0) && (steer_r == '0))
    else $error("commands not cleared on turn-on");

  a_estop_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ESTOP) && ($past(mode_r) == MODE_ON) |->
      (steer_r == '0) && (throttle_r == $signed({1'b0, $past(max_brake_r)})))
    else $error("emergency stop entered without brake and zero steer");

  a_no_skip_from_off: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ESTOP) && ($past(mode_r) != MODE_ESTOP) |->
      ($past(mode_r) == MODE_ON))
    else $error("emergency stop reached from a mode other than on");

  a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced event produced no result beat");

endmodule

`default_nettype wire

// ----- verif/jdd_drive_scoreboard_pkg.sv -----
// Scoreboard for the joystick dead-man drive control test: mode/command predictor
// and a queue of expected drive commands checked in order.
// Depends on jdd_pkg.
`timescale 1ns / 1ps

package jdd_drive_scoreboard_pkg;
  import jdd_pkg::*;

  localparam int FULL_SCALE = 32767;
  localparam int MAX_PRINTED_ERRORS = 200;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [CMD_W-1:0] throttle;
    logic signed [CMD_W-1:0] steer;
  } drive_cmd_t;

  class drive_scoreboard;
    logic [SCALE_W-1:0]      brake_scale;
    logic [SCALE_W-1:0]      throttle_scale;
    logic [SCALE_W-1:0]      steer_scale;
    mode_t                   cur_mode;
    logic signed [CMD_W-1:0] cur_throttle;
    logic signed [CMD_W-1:0] cur_steer;
    drive_cmd_t              expected_cmds[$];
    int unsigned             errors;

    function new();
      brake_scale    = MAX_BRAKE_RST;
      throttle_scale = MAX_THROTTLE_RST;
      steer_scale    = MAX_STEER_RST;
      cur_mode       = MODE_OFF;
      cur_throttle   = '0;
      cur_steer      = '0;
      errors         = 0;
    endfunction

    function int unsigned pending();
      return expected_cmds.size();
    endfunction

    function void set_scale(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] value);
      case (idx)
        CFG_MAX_BRAKE:    brake_scale = value;
        CFG_MAX_THROTTLE: throttle_scale = value;
        CFG_MAX_STEER:    steer_scale = value;
        default: ;
      endcase
    endfunction

    // Truncates toward zero, as integer division does.
    function int stick_scale(int value, int factor);
      return (value * factor) / FULL_SCALE;
    endfunction

    function void note_event(logic [KIND_W-1:0] kind, logic [NUM_W-1:0] num,
                             logic signed [VAL_W-1:0] val);
      logic signed [VAL_W-1:0] pushed;
      drive_cmd_t              cmd;
      if (cur_mode == MODE_ON) begin
        if (kind == KIND_AXIS) begin
          if (num == AXIS_TRIGGER) begin
            if (val < SWITCH_OFF_LEVEL) begin
              cur_mode     = MODE_ESTOP;
              cur_throttle = signed'({1'b0, brake_scale});
              cur_steer    = '0;
            end
          end else if (num == AXIS_STICK_Y) begin
            // Stick Y is inverted; full negative deflection wraps back to itself.
            pushed = -val;
            if (pushed > 0)
              cur_throttle = CMD_W'(stick_scale(int'(pushed), int'(throttle_scale)));
            else
              cur_throttle = CMD_W'(stick_scale(int'(pushed), int'(brake_scale)));
          end else if (num == AXIS_STICK_X) begin
            cur_steer = CMD_W'(stick_scale(int'(val), int'(steer_scale)));
          end
        end
      end else begin
        if (cur_mode == MODE_ESTOP && kind == KIND_BUTTON && num == BUTTON_RELEASE) begin
          cur_mode = MODE_OFF;
        end else if (kind == KIND_AXIS && num == AXIS_TRIGGER && val > SWITCH_ON_LEVEL) begin
          cur_mode     = MODE_ON;
          cur_throttle = '0;
          cur_steer    = '0;
        end
      end
      cmd.mode     = cur_mode;
      cmd.throttle = cur_throttle;
      cmd.steer    = cur_steer;
      expected_cmds.push_back(cmd);
    endfunction

    task report(string what);
      if (errors < MAX_PRINTED_ERRORS)
        $display("ERROR at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [MODE_W-1:0] mode, logic signed [CMD_W-1:0] throttle,
                      logic signed [CMD_W-1:0] steer);
      drive_cmd_t want;
      if (expected_cmds.size() == 0) begin
        report($sformatf("command beat with no event pending: mode %0d thr %0d steer %0d",
                         mode, throttle, steer));
      end else begin
        want = expected_cmds.pop_front();
        if (mode !== want.mode)
          report($sformatf("mode %0d, expected %0d", mode, want.mode));
        if (throttle !== want.throttle)
          report($sformatf("throttle_cmd %0d, expected %0d", throttle, want.throttle));
        if (steer !== want.steer)
          report($sformatf("steer_cmd %0d, expected %0d", steer, want.steer));
      end
    endtask
  endclass

endpackage

// ----- verif/joystick_deadman_drive_control_test.sv -----
// Test of joystick_deadman_drive_control: directed and random gamepad events under
// random idling on both channels, several scale settings, results checked in order.
// Depends on jdd_pkg, jdd_in_if, jdd_out_if and jdd_drive_scoreboard_pkg.
`timescale 1ns / 1ps

module joystick_deadman_drive_control_test import jdd_pkg::*, jdd_drive_scoreboard_pkg::*;;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 6;
  localparam int PHASES        = 10;
  localparam int CALM_PHASES   = 2;
  localparam int PHASE_EVENTS  = 150;
  localparam int MAX_IDLE      = 12;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [NUM_W-1:0]        num;
    logic signed [VAL_W-1:0] val;
  } pad_event_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [SCALE_W-1:0]   cfg_wdata;

  jdd_in_if  ev_ch ();
  jdd_out_if cmd_ch ();

  joystick_deadman_drive_control u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (ev_ch),
    .out_ch    (cmd_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  drive_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  bit              calm = 1'b0;
  int unsigned     send_gap_pct = 20;
  int unsigned     stall_pct = 20;
  int unsigned     stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Note each accepted event and check each accepted command beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (ev_ch.valid && ev_ch.ready)
        sb.note_event(ev_ch.event_kind, ev_ch.control_number, ev_ch.event_value);
      if (cmd_ch.valid && cmd_ch.ready)
        sb.check_result(cmd_ch.mode, cmd_ch.throttle_cmd, cmd_ch.steer_cmd);
    end
  end

  // Result side back-pressure in bursts.
  initial begin
    cmd_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0)
        stall_left--;
      else if (!calm && $urandom_range(99) < stall_pct)
        stall_left = $urandom_range(MAX_IDLE, 1);
      cmd_ch.ready <= (stall_left == 0);
    end
  end

  task automatic send_event(input logic [KIND_W-1:0] kind, input logic [NUM_W-1:0] num,
                            input logic signed [VAL_W-1:0] val);
    int unsigned gap;
    @(negedge clk);
    if (!calm && $urandom_range(99) < send_gap_pct) begin
      gap = $urandom_range(MAX_IDLE, 1);
      ev_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    ev_ch.valid          <= 1'b1;
    ev_ch.event_kind     <= kind;
    ev_ch.control_number <= num;
    ev_ch.event_value    <= val;
    do @(posedge clk); while (!ev_ch.ready);
  endtask

  // Drop valid and wait until every expected command beat is back.
  task automatic drain_events();
    @(negedge clk);
    ev_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    sb.set_scale(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return SCALE_W'($urandom_range(2 ** SCALE_W - 1));
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] stick_extreme();
    case ($urandom_range(3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh8001;
      default: return '0;
    endcase
  endfunction

  // Mostly well-formed driving: arm, steer, stop, release; the rest is noise.
  function automatic pad_event_t random_pad_event();
    pad_event_t  e;
    int unsigned pick;
    pick   = $urandom_range(99);
    e.kind = KIND_AXIS;
    e.val  = VAL_W'($urandom);
    if (pick < 16) begin
      e.num = AXIS_TRIGGER;
      case ($urandom_range(3))
        0: e.val = VAL_W'($urandom_range(32767, 25001));
        1: e.val = VAL_W'(-$urandom_range(32768, 5001));
        2: begin
          case ($urandom_range(3))
            0:       e.val = SWITCH_ON_LEVEL;
            1:       e.val = SWITCH_ON_LEVEL + 16'sd1;
            2:       e.val = SWITCH_OFF_LEVEL;
            default: e.val = SWITCH_OFF_LEVEL - 16'sd1;
          endcase
        end
        default: ;
      endcase
    end else if (pick < 46) begin
      e.num = AXIS_STICK_Y;
      if ($urandom_range(7) == 0) e.val = stick_extreme();
    end else if (pick < 76) begin
      e.num = AXIS_STICK_X;
      if ($urandom_range(7) == 0) e.val = stick_extreme();
    end else if (pick < 88) begin
      e.kind = KIND_BUTTON;
      e.num  = $urandom_range(1) ? BUTTON_RELEASE : NUM_W'($urandom);
    end else begin
      e.kind = KIND_W'($urandom);
      e.num  = NUM_W'($urandom);
    end
    return e;
  endfunction

  initial begin
    logic [SCALE_W-1:0] brake_set;
    logic [SCALE_W-1:0] throttle_set;
    logic [SCALE_W-1:0] steer_set;
    pad_event_t         e;

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = CFG_MAX_BRAKE;
    cfg_wdata            = '0;
    ev_ch.valid          = 1'b0;
    ev_ch.event_kind     = KIND_BUTTON;
    ev_ch.control_number = '0;
    ev_ch.event_value    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass at reset scales.
    send_event(KIND_BUTTON, BUTTON_RELEASE, 16'sd1);      // button while off
    send_event(KIND_AXIS, AXIS_STICK_Y, 16'sd1000);       // stick ignored while off
    send_event(KIND_AXIS, AXIS_TRIGGER, SWITCH_ON_LEVEL); // at level: stays off
    send_event(KIND_AXIS, AXIS_TRIGGER, SWITCH_ON_LEVEL + 16'sd1);
    send_event(KIND_AXIS, AXIS_STICK_Y, 16'sh8000);       // negation wraps: brake scale
    send_event(KIND_AXIS, AXIS_STICK_Y, 16'sh7fff);
    send_event(KIND_AXIS, AXIS_STICK_Y, 16'sh8001);
    send_event(KIND_AXIS, AXIS_STICK_Y, 16'sd0);
    send_event(KIND_AXIS, AXIS_STICK_X, 16'sh7fff);
    send_event(KIND_AXIS, AXIS_STICK_X, 16'sh8000);
    send_event(KIND_AXIS, 8'd5, 16'sh7fff);               // unused axis
    send_event(2'd2, AXIS_TRIGGER, 16'sh8000);            // other event kinds
    send_event(2'd3, 8'hff, 16'sh8000);
    send_event(KIND_BUTTON, BUTTON_RELEASE, 16'sd1);      // button while on
    send_event(KIND_AXIS, AXIS_TRIGGER, SWITCH_OFF_LEVEL);
    send_event(KIND_AXIS, AXIS_TRIGGER, SWITCH_OFF_LEVEL - 16'sd1);
    send_event(KIND_AXIS, AXIS_STICK_X, 16'sd20000);      // ignored in stop
    send_event(KIND_BUTTON, BUTTON_RELEASE, 16'sd0);      // release, any value
    send_event(KIND_AXIS, AXIS_TRIGGER, 16'sh7fff);
    send_event(KIND_AXIS, AXIS_TRIGGER, 16'sh8000);
    send_event(KIND_AXIS, AXIS_TRIGGER, 16'sd30000);      // rearm straight from stop
    send_event(KIND_AXIS, AXIS_TRIGGER, 16'sh8000);
    send_event(KIND_BUTTON, 8'd2, 16'sd1);
    send_event(KIND_BUTTON, BUTTON_RELEASE, 16'sd1);
    drain_events();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin brake_set = '1; throttle_set = '1; steer_set = '1; end
        1: begin brake_set = '0; throttle_set = '0; steer_set = '0; end
        2: begin brake_set = '1; throttle_set = '0; steer_set = 10'd1; end
        default: begin
          brake_set    = pick_scale();
          throttle_set = pick_scale();
          steer_set    = pick_scale();
        end
      endcase
      write_scale(CFG_MAX_BRAKE, brake_set);
      write_scale(CFG_MAX_THROTTLE, throttle_set);
      write_scale(CFG_MAX_STEER, steer_set);

      calm = (phase >= PHASES - CALM_PHASES);
      case ($urandom_range(2))
        0:       send_gap_pct = 0;
        1:       send_gap_pct = 10;
        default: send_gap_pct = 40;
      endcase
      case ($urandom_range(2))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        default: stall_pct = 40;
      endcase

      for (int i = 0; i < PHASE_EVENTS; i++) begin
        e = random_pad_event();
        send_event(e.kind, e.num, e.val);
      end
      drain_events();
    end

    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
